@@ rtl/sha1h_pkg.sv @@
// Shared types, constants and helper functions for the SHA-1 hash unit.
package sha1h_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } sha1h_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_digest;
  } sha1h_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LENLO,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } sha1h_state_t;

  typedef enum logic [2:0] {
    SEL_IN,
    SEL_PAD,
    SEL_ZERO,
    SEL_LENHI,
    SEL_LENLO
  } sha1h_wsel_t;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } sha1h_phase_t;

  typedef struct packed {
    logic         push;
    sha1h_wsel_t  wsel;
    logic         len_add;
    logic         round_en;
    sha1h_phase_t phase;
    logic         update;
    logic         restart;
    logic [2:0]   out_idx;
  } sha1h_cmd_t;

  typedef struct packed {
    logic block_full;
    logic at_len_slot;
  } sha1h_status_t;

  localparam logic [31:0] H_INIT [5] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
  };

  localparam logic [31:0] K_CH   = 32'h5a82_7999;
  localparam logic [31:0] K_PAR1 = 32'h6ed9_eba1;
  localparam logic [31:0] K_MAJ  = 32'h8f1b_bcdc;
  localparam logic [31:0] K_PAR2 = 32'hca62_c1d6;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [31:0] PAD_WORD   = {PAD_BYTE, 24'h00_0000};
  localparam logic [2:0]  FULL_BYTES = 3'd4;
  localparam logic [3:0]  LAST_SLOT  = 4'd15;
  localparam logic [3:0]  LEN_SLOT   = 4'd14;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [6:0]  PH1_START  = 7'd20;
  localparam logic [6:0]  PH2_START  = 7'd40;
  localparam logic [6:0]  PH3_START  = 7'd60;
  localparam logic [2:0]  LAST_IDX   = 3'd4;

  // Final word of a message holding fewer than four bytes: keep the valid
  // leading bytes and place the pad byte right after them.
  function automatic logic [31:0] pad_word(input logic [31:0] data,
                                           input logic [2:0]  nb);
    logic [31:0] w;
    unique case (nb)
      3'd0:    w = PAD_WORD;
      3'd1:    w = {data[31:24], PAD_BYTE, 16'h0000};
      3'd2:    w = {data[31:16], PAD_BYTE, 8'h00};
      3'd3:    w = {data[31:8], PAD_BYTE};
      default: w = data;
    endcase
    return w;
  endfunction

  // Message bits added by one input word.
  function automatic logic [5:0] len_incr(input logic [2:0] nb, input logic last);
    logic [5:0] v;
    if (!last || nb >= FULL_BYTES) begin
      v = 6'd32;
    end else begin
      v = {nb, 3'b000};
    end
    return v;
  endfunction

endpackage

@@ rtl/sha1h_ctrl.sv @@
// Sequencing state machine for the SHA-1 hash unit: padding, rounds, digest output.
module sha1h_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_last,
  input  logic [2:0]              in_nb,
  input  logic                    out_stall,
  input  sha1h_pkg::sha1h_status_t status,
  output logic                    in_stall,
  output logic                    out_valid,
  output sha1h_pkg::sha1h_cmd_t   cmd
);

  sha1h_pkg::sha1h_state_t state_r, state_nxt;
  sha1h_pkg::sha1h_state_t ret_r, ret_nxt;
  sha1h_pkg::sha1h_state_t after;
  logic [6:0] cnt_r, cnt_nxt;
  logic [2:0] oidx_r, oidx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1h_pkg::ST_IDLE;
      ret_r   <= sha1h_pkg::ST_IDLE;
      cnt_r   <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  // Next state. A push that completes a block detours through the rounds
  // and comes back to the state that would have followed.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    after     = state_r;
    unique case (state_r)
      sha1h_pkg::ST_IDLE: begin
        if (!in_last) begin
          after = sha1h_pkg::ST_IDLE;
        end else if (in_nb >= sha1h_pkg::FULL_BYTES) begin
          after = sha1h_pkg::ST_PAD;
        end else begin
          after = sha1h_pkg::ST_ZERO;
        end
        if (in_valid) begin
          if (status.block_full) begin
            state_nxt = sha1h_pkg::ST_ROUND;
            ret_nxt   = after;
          end else begin
            state_nxt = after;
          end
        end
      end
      sha1h_pkg::ST_PAD: begin
        after = sha1h_pkg::ST_ZERO;
        if (status.block_full) begin
          state_nxt = sha1h_pkg::ST_ROUND;
          ret_nxt   = after;
        end else begin
          state_nxt = after;
        end
      end
      sha1h_pkg::ST_ZERO: begin
        after = sha1h_pkg::ST_ZERO;
        if (status.at_len_slot) begin
          state_nxt = sha1h_pkg::ST_LENLO;
        end else if (status.block_full) begin
          state_nxt = sha1h_pkg::ST_ROUND;
          ret_nxt   = after;
        end
      end
      sha1h_pkg::ST_LENLO: begin
        state_nxt = sha1h_pkg::ST_ROUND;
        ret_nxt   = sha1h_pkg::ST_OUT;
      end
      sha1h_pkg::ST_ROUND: begin
        if (cnt_r == sha1h_pkg::LAST_ROUND) begin
          state_nxt = sha1h_pkg::ST_UPDATE;
        end
      end
      sha1h_pkg::ST_UPDATE: begin
        state_nxt = ret_r;
      end
      sha1h_pkg::ST_OUT: begin
        if (!out_stall && oidx_r == sha1h_pkg::LAST_IDX) begin
          state_nxt = sha1h_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sha1h_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt  = (state_r == sha1h_pkg::ST_ROUND) ? cnt_r + 7'd1 : '0;
    oidx_nxt = oidx_r;
    if (state_r == sha1h_pkg::ST_OUT && !out_stall) begin
      oidx_nxt = (oidx_r == sha1h_pkg::LAST_IDX) ? '0 : oidx_r + 3'd1;
    end
  end

  // Outputs and datapath commands.
  always_comb begin
    in_stall     = (state_r != sha1h_pkg::ST_IDLE);
    out_valid    = (state_r == sha1h_pkg::ST_OUT);
    cmd          = '0;
    cmd.wsel     = sha1h_pkg::SEL_IN;
    cmd.phase    = sha1h_pkg::PH_CH;
    cmd.out_idx  = oidx_r;
    if (cnt_r >= sha1h_pkg::PH3_START) begin
      cmd.phase = sha1h_pkg::PH_PAR2;
    end else if (cnt_r >= sha1h_pkg::PH2_START) begin
      cmd.phase = sha1h_pkg::PH_MAJ;
    end else if (cnt_r >= sha1h_pkg::PH1_START) begin
      cmd.phase = sha1h_pkg::PH_PAR1;
    end
    unique case (state_r)
      sha1h_pkg::ST_IDLE: begin
        cmd.push    = in_valid;
        cmd.len_add = in_valid;
      end
      sha1h_pkg::ST_PAD: begin
        cmd.push = 1'b1;
        cmd.wsel = sha1h_pkg::SEL_PAD;
      end
      sha1h_pkg::ST_ZERO: begin
        cmd.push = 1'b1;
        cmd.wsel = status.at_len_slot ? sha1h_pkg::SEL_LENHI : sha1h_pkg::SEL_ZERO;
      end
      sha1h_pkg::ST_LENLO: begin
        cmd.push = 1'b1;
        cmd.wsel = sha1h_pkg::SEL_LENLO;
      end
      sha1h_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      sha1h_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      sha1h_pkg::ST_OUT: begin
        cmd.restart = !out_stall && (oidx_r == sha1h_pkg::LAST_IDX);
      end
      default: begin
        cmd.push = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/sha1h_dp.sv @@
// Datapath of the SHA-1 hash unit: schedule shift line, round logic, chaining value.
module sha1h_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sha1h_pkg::sha1h_in_t     in_data,
  input  sha1h_pkg::sha1h_cmd_t    cmd,
  output sha1h_pkg::sha1h_status_t status,
  output logic [31:0]              digest_word
);

  logic [31:0] h_r [5];
  logic [31:0] sched_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [63:0] len_r;
  logic [3:0]  pos_r;

  logic [31:0] in_word;
  logic [31:0] push_word;
  logic [31:0] w_mix, w_new;
  logic [31:0] f, k, tmp;
  logic        fill;

  always_comb begin
    if (!in_data.last_word || in_data.byte_count >= sha1h_pkg::FULL_BYTES) begin
      in_word = in_data.data_word;
    end else begin
      in_word = sha1h_pkg::pad_word(in_data.data_word, in_data.byte_count);
    end
    unique case (cmd.wsel)
      sha1h_pkg::SEL_IN:    push_word = in_word;
      sha1h_pkg::SEL_PAD:   push_word = sha1h_pkg::PAD_WORD;
      sha1h_pkg::SEL_LENHI: push_word = len_r[63:32];
      sha1h_pkg::SEL_LENLO: push_word = len_r[31:0];
      default:              push_word = '0;
    endcase
  end

  // The schedule line always holds W[t] .. W[t+15] in slots 0 .. 15.
  assign w_mix = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    unique case (cmd.phase)
      sha1h_pkg::PH_CH: begin
        f = (b_r & c_r) ^ (~b_r & d_r);
        k = sha1h_pkg::K_CH;
      end
      sha1h_pkg::PH_PAR1: begin
        f = b_r ^ c_r ^ d_r;
        k = sha1h_pkg::K_PAR1;
      end
      sha1h_pkg::PH_MAJ: begin
        f = (b_r & c_r) ^ (b_r & d_r) ^ (c_r & d_r);
        k = sha1h_pkg::K_MAJ;
      end
      default: begin
        f = b_r ^ c_r ^ d_r;
        k = sha1h_pkg::K_PAR2;
      end
    endcase
    tmp = {a_r[26:0], a_r[31:27]} + f + e_r + k + sched_r[0];
  end

  assign fill               = cmd.push && (pos_r == sha1h_pkg::LAST_SLOT);
  assign status.block_full  = (pos_r == sha1h_pkg::LAST_SLOT);
  assign status.at_len_slot = (pos_r == sha1h_pkg::LEN_SLOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pos_r <= '0;
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= sha1h_pkg::H_INIT[i];
      end
    end else begin
      if (cmd.restart) begin
        len_r <= '0;
        pos_r <= '0;
        for (int i = 0; i < 5; i++) begin
          h_r[i] <= sha1h_pkg::H_INIT[i];
        end
      end else begin
        if (cmd.len_add) begin
          len_r <= len_r + {58'd0, sha1h_pkg::len_incr(in_data.byte_count,
                                                       in_data.last_word)};
        end
        if (cmd.push) begin
          pos_r <= pos_r + 4'd1;
        end
        if (cmd.update) begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[15] <= cmd.push ? push_word : w_new;
    end
    if (fill) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_en) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_comb begin
    unique case (cmd.out_idx)
      3'd1:    digest_word = h_r[1];
      3'd2:    digest_word = h_r[2];
      3'd3:    digest_word = h_r[3];
      3'd4:    digest_word = h_r[4];
      default: digest_word = h_r[0];
    endcase
  end

endmodule

@@ rtl/sha1_hash_unit.sv @@
// Top level of the SHA-1 hash unit: controller and datapath joined by commands.
// Usage: the message enters as big-endian 32-bit words on the input channel
// (in_valid / in_stall / in_data), one word per transaction. A word with
// last_word set ends the message; its byte_count (0 to 4, larger values act
// as 4) gives the valid leading bytes. The unit appends standard SHA-1
// padding and the 64-bit bit length itself, adding an extra block when the
// length does not fit.
// Each completed 512-bit block runs 80 rounds, one round per cycle through
// a single round unit fed by a 16-word schedule shift line, followed by the
// chaining update. After the final word, the padding words are pushed one
// per cycle and one or two compressions follow before the first digest
// word is offered. The five digest words H0..H4 then appear as five
// transactions on the output channel (out_valid / out_stall / out_data),
// last_digest marking H4. The unit takes no input while it pads,
// compresses or presents the digest: in_stall is high throughout.
// When the receiver stalls, the current digest word is held unchanged.
// After H4 is taken the unit restarts from the initial hash value.
// Reset (rst_n low, synchronous) returns to the idle state with the
// initial hash value, a zero bit count and an empty block.
module sha1_hash_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha1h_pkg::sha1h_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha1h_pkg::sha1h_out_t out_data
);

  sha1h_pkg::sha1h_cmd_t    cmd;
  sha1h_pkg::sha1h_status_t status;
  logic [31:0]              digest_word;

  // The controller decides the padding sequence from the last word's flags.
  sha1h_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_word),
    .in_nb     (in_data.byte_count),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  sha1h_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .status      (status),
    .digest_word (digest_word)
  );

  // The digest word comes straight from the chaining registers, which do
  // not move while the output transaction waits.
  assign out_data.digest_word = digest_word;
  assign out_data.last_digest = (cmd.out_idx == sha1h_pkg::LAST_IDX);

endmodule

@@ rtl/sha1h_checker.sv @@
// Port-level assertions for the SHA-1 hash unit and their bind to the top level.
module sha1h_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input sha1h_pkg::sha1h_in_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input sha1h_pkg::sha1h_out_t out_data
);

  // A waiting digest word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("digest word changed while stalled");

  // No input is taken while digest words are presented.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during digest output");

  // The digest cannot follow the final word immediately.
  a_no_early_digest: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_word |=> !out_valid)
    else $error("digest appeared right after the final word");

  // The five digest words are back to back when not stalled.
  a_digest_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_digest |=> out_valid)
    else $error("digest burst broken");

  // After the fifth word the output channel goes quiet and the input channel is no longer stalled.
  a_digest_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_digest |=> !out_valid && !in_stall)
    else $error("unit did not return to idle after the digest");

endmodule

bind sha1_hash_unit sha1h_checker u_sha1h_checker (.*);
